[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the console RTL
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/tccs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_pkg
// Types, constants and the microcode table of the text console engine.
// ----------------------------------------------------------------------------
package tccs_pkg;

	localparam int SCREEN_COLUMNS_DEF = 80;
	localparam int SCREEN_ROWS_DEF    = 25;

	localparam int OP_W        = 2;
	localparam int BYTE_W      = 8;
	localparam int CELL_W      = 16;
	localparam int COL_FIELD_W = 7;
	localparam int ROW_FIELD_W = 5;
	localparam int CFG_IDX_W   = 1;

	localparam logic [BYTE_W-1:0] BLANK_CHAR = 8'h20;
	localparam logic [BYTE_W-1:0] ATTR_RESET = 8'h07;

	typedef enum logic [OP_W-1:0] {
		OP_SHOW       = 2'd0,
		OP_CLEAR      = 2'd1,
		OP_SET_CURSOR = 2'd2,
		OP_READ_CELL  = 2'd3
	} op_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLEAR_ATTR  = 1'b0,
		REG_SCROLL_ATTR = 1'b1
	} reg_idx_e;

	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_FETCH    = 4'd0;
	localparam step_t STEP_SHOW     = 4'd1;
	localparam step_t STEP_CP_RD    = 4'd2;
	localparam step_t STEP_CP_WR    = 4'd3;
	localparam step_t STEP_FL_SET   = 4'd4;
	localparam step_t STEP_FL_WR    = 4'd5;
	localparam step_t STEP_SCR_DONE = 4'd6;
	localparam step_t STEP_CLR_WR   = 4'd7;
	localparam step_t STEP_CLR_DONE = 4'd8;
	localparam step_t STEP_SET_CUR  = 4'd9;
	localparam step_t STEP_RD_ISSUE = 4'd10;
	localparam step_t STEP_RD_DONE  = 4'd11;
	localparam step_t STEP_LAST     = STEP_RD_DONE;

	typedef enum logic [2:0] {
		CND_NEXT,       // fall through; a result step returns to fetch
		CND_GOTO,       // always jump
		CND_DISPATCH,   // wait for a transaction, jump by operation
		CND_PTR_MORE,   // jump while the sweep pointer is not at the last cell
		CND_SCREEN_END  // jump when the cursor sits on the last cell
	} cond_e;

	typedef enum logic [1:0] {
		WD_SHOW,
		WD_COPY,
		WD_SCROLL_BLANK,
		WD_CLEAR_BLANK
	} wsel_e;

	typedef enum logic [1:0] {
		WA_CURSOR,
		WA_PTR,
		WA_PTR_UP
	} waddr_e;

	typedef enum logic {
		RA_PTR,
		RA_CELL
	} raddr_e;

	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_ZERO,
		PTR_COLUMNS,
		PTR_LAST_ROW,
		PTR_INC
	} ptr_op_e;

	typedef enum logic [1:0] {
		CUR_HOLD,
		CUR_ADVANCE,
		CUR_HOME,
		CUR_LOAD
	} cur_op_e;

	typedef struct packed {
		cond_e   cond;
		step_t   target;
		logic    latch_in;
		logic    mem_we;
		wsel_e   wsel;
		waddr_e  waddr;
		logic    mem_re;
		raddr_e  raddr;
		ptr_op_e ptr_op;
		cur_op_e cur_op;
		logic    emit;
		logic    scroll_flag;
		logic    read_flag;
	} ucw_t;

	// sequencer -> datapath
	typedef struct packed {
		logic go;         // step takes effect this cycle
		logic emit_fire;  // result register loads this cycle
		ucw_t uw;
	} ctrl_t;

	// datapath -> sequencer
	typedef struct packed {
		logic ptr_last;
		logic screen_end;
	} stat_t;

	localparam ucw_t UCW_NOP = '{
		cond: CND_GOTO, target: STEP_FETCH, latch_in: 1'b0, mem_we: 1'b0,
		wsel: WD_SHOW, waddr: WA_CURSOR, mem_re: 1'b0, raddr: RA_PTR,
		ptr_op: PTR_HOLD, cur_op: CUR_HOLD, emit: 1'b0, scroll_flag: 1'b0,
		read_flag: 1'b0
	};

	function automatic ucw_t ucode_rom(step_t s);
		ucw_t w;
		w = UCW_NOP;
		case (s)
			STEP_FETCH: begin
				w.cond     = CND_DISPATCH;
				w.latch_in = 1'b1;
				w.ptr_op   = PTR_ZERO;
			end
			STEP_SHOW: begin
				// advance also lands on the scroll position at the last cell
				w.cond   = CND_SCREEN_END;
				w.target = STEP_CP_RD;
				w.mem_we = 1'b1;
				w.wsel   = WD_SHOW;
				w.waddr  = WA_CURSOR;
				w.ptr_op = PTR_COLUMNS;
				w.cur_op = CUR_ADVANCE;
				w.emit   = 1'b1;
			end
			STEP_CP_RD: begin
				w.cond   = CND_NEXT;
				w.mem_re = 1'b1;
				w.raddr  = RA_PTR;
			end
			STEP_CP_WR: begin
				w.cond   = CND_PTR_MORE;
				w.target = STEP_CP_RD;
				w.mem_we = 1'b1;
				w.wsel   = WD_COPY;
				w.waddr  = WA_PTR_UP;
				w.ptr_op = PTR_INC;
			end
			STEP_FL_SET: begin
				w.cond   = CND_NEXT;
				w.ptr_op = PTR_LAST_ROW;
			end
			STEP_FL_WR: begin
				w.cond   = CND_PTR_MORE;
				w.target = STEP_FL_WR;
				w.mem_we = 1'b1;
				w.wsel   = WD_SCROLL_BLANK;
				w.waddr  = WA_PTR;
				w.ptr_op = PTR_INC;
			end
			STEP_SCR_DONE: begin
				w.cond        = CND_NEXT;
				w.emit        = 1'b1;
				w.scroll_flag = 1'b1;
			end
			STEP_CLR_WR: begin
				w.cond   = CND_PTR_MORE;
				w.target = STEP_CLR_WR;
				w.mem_we = 1'b1;
				w.wsel   = WD_CLEAR_BLANK;
				w.waddr  = WA_PTR;
				w.ptr_op = PTR_INC;
			end
			STEP_CLR_DONE: begin
				w.cond   = CND_NEXT;
				w.cur_op = CUR_HOME;
				w.emit   = 1'b1;
			end
			STEP_SET_CUR: begin
				w.cond   = CND_NEXT;
				w.cur_op = CUR_LOAD;
				w.emit   = 1'b1;
			end
			STEP_RD_ISSUE: begin
				w.cond   = CND_NEXT;
				w.mem_re = 1'b1;
				w.raddr  = RA_CELL;
			end
			STEP_RD_DONE: begin
				w.cond      = CND_NEXT;
				w.emit      = 1'b1;
				w.read_flag = 1'b1;
			end
			default: w = UCW_NOP;
		endcase
		return w;
	endfunction

	function automatic step_t dispatch_step(op_e op);
		step_t s;
		case (op)
			OP_SHOW:       s = STEP_SHOW;
			OP_CLEAR:      s = STEP_CLR_WR;
			OP_SET_CURSOR: s = STEP_SET_CUR;
			OP_READ_CELL:  s = STEP_RD_ISSUE;
			default:       s = STEP_FETCH;
		endcase
		return s;
	endfunction

endpackage

[hw/rtl/text_console_cursor_scroll.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text-mode console: cell store, linear cursor, wrap and one-row scroll.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one command per transaction:
//   show, clear, set cursor or read cell. Every command returns exactly one
//   result on the output channel (out_valid/out_ready): cursor position
//   after the command, the cell read (zero otherwise) and a scroll flag.
//   Commands run one at a time on a microcoded sequencer; the cell store has
//   one write and one registered read port, which sets the sweep lengths.
//   The result is registered; out_valid rises the cycle after the last step.
//   A next command is accepted while a result waits; a command ready to
//   return its result holds when the receiver stalls.
//   Reset homes the cursor and sets both blank attributes to 7. The store is
//   not cleared by reset: issue clear before reading cells. The user writes
//   configuration (cfg_write/cfg_index/cfg_data) only when idle; unenforced.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_cursor_scroll #(
	parameter int SCREEN_COLUMNS = tccs_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_ROWS    = tccs_pkg::SCREEN_ROWS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [tccs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tccs_pkg::BYTE_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [tccs_pkg::OP_W-1:0]           operation,
	input  logic [tccs_pkg::BYTE_W-1:0]         character,
	input  logic [tccs_pkg::BYTE_W-1:0]         attribute,
	input  logic [tccs_pkg::COL_FIELD_W-1:0]    cell_column,
	input  logic [tccs_pkg::ROW_FIELD_W-1:0]    cell_row,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [tccs_pkg::COL_FIELD_W-1:0]    cursor_column,
	output logic [tccs_pkg::ROW_FIELD_W-1:0]    cursor_row,
	output logic [tccs_pkg::BYTE_W-1:0]         cell_character,
	output logic [tccs_pkg::BYTE_W-1:0]         cell_attribute,
	output logic                                did_scroll
);
	import tccs_pkg::*;

	ctrl_t                   ctrl;
	stat_t                   stat;
	logic                    out_valid_q;
	logic                    out_busy;
	logic [COL_FIELD_W-1:0]  next_column, column_q;
	logic [ROW_FIELD_W-1:0]  next_row, row_q;
	logic [CELL_W-1:0]       read_cell;
	logic [BYTE_W-1:0]       char_out_q, attr_out_q;
	logic                    scroll_q;

	assign out_busy = out_valid_q && !out_ready;

	tccs_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.stat      (stat),
		.out_busy  (out_busy),
		.in_ready  (in_ready),
		.ctrl      (ctrl)
	);

	tccs_dp #(
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.character   (character),
		.attribute   (attribute),
		.cell_column (cell_column),
		.cell_row    (cell_row),
		.stat        (stat),
		.next_column (next_column),
		.next_row    (next_row),
		.read_cell   (read_cell)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit_fire) begin
			column_q   <= next_column;
			row_q      <= next_row;
			char_out_q <= ctrl.uw.read_flag ? read_cell[BYTE_W-1:0] : '0;
			attr_out_q <= ctrl.uw.read_flag ? read_cell[CELL_W-1:BYTE_W] : '0;
			scroll_q   <= ctrl.uw.scroll_flag;
		end
	end

	assign out_valid      = out_valid_q;
	assign cursor_column  = column_q;
	assign cursor_row     = row_q;
	assign cell_character = char_out_q;
	assign cell_attribute = attr_out_q;
	assign did_scroll     = scroll_q;

	`ASSERT_IMPL(a_no_overwrite, ctrl.emit_fire, !out_busy, "result overwritten before taken")

endmodule

[hw/rtl/tccs_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_seq
// Step counter and microcode table; evaluates jumps and stalls on a busy
// result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tccs_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [tccs_pkg::OP_W-1:0]      operation,
	input  tccs_pkg::stat_t                stat,
	input  logic                           out_busy,
	output logic                           in_ready,
	output tccs_pkg::ctrl_t                ctrl
);
	import tccs_pkg::*;

	step_t upc_q;
	step_t upc_next;
	ucw_t  uw;
	logic  taken;
	logic  stall;
	logic  accept;

	assign uw       = ucode_rom(upc_q);
	assign in_ready = (uw.cond == CND_DISPATCH);
	assign accept   = in_valid && in_ready;

	always_comb begin
		case (uw.cond)
			CND_GOTO:       taken = 1'b1;
			CND_PTR_MORE:   taken = !stat.ptr_last;
			CND_SCREEN_END: taken = stat.screen_end;
			default:        taken = 1'b0;
		endcase
		// a result step waits while the previous result is not taken
		stall = uw.emit && !taken && out_busy;

		ctrl.uw        = uw;
		ctrl.go        = (uw.cond == CND_DISPATCH) ? accept : !stall;
		ctrl.emit_fire = uw.emit && !taken && !stall;

		if (uw.cond == CND_DISPATCH) begin
			upc_next = accept ? dispatch_step(op_e'(operation)) : upc_q;
		end else if (stall) begin
			upc_next = upc_q;
		end else if (taken) begin
			upc_next = uw.target;
		end else if (uw.emit) begin
			upc_next = STEP_FETCH;
		end else begin
			upc_next = upc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= STEP_FETCH;
		end else begin
			upc_q <= upc_next;
		end
	end

	`ASSERT_ALWAYS(a_upc_in_program, upc_q <= STEP_LAST, "step counter left the program")
	`ASSERT_NEXT(a_emit_returns, ctrl.emit_fire, in_ready, "no return to fetch after result")

endmodule

[hw/rtl/tccs_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_dp
// Console datapath: cursor, sweep pointer, cell store, attribute registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tccs_dp #(
	parameter int SCREEN_COLUMNS = tccs_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_ROWS    = tccs_pkg::SCREEN_ROWS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tccs_pkg::ctrl_t                     ctrl,
	input  logic                                cfg_write,
	input  logic [tccs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tccs_pkg::BYTE_W-1:0]         cfg_data,
	input  logic [tccs_pkg::BYTE_W-1:0]         character,
	input  logic [tccs_pkg::BYTE_W-1:0]         attribute,
	input  logic [tccs_pkg::COL_FIELD_W-1:0]    cell_column,
	input  logic [tccs_pkg::ROW_FIELD_W-1:0]    cell_row,
	output tccs_pkg::stat_t                     stat,
	output logic [tccs_pkg::COL_FIELD_W-1:0]    next_column,
	output logic [tccs_pkg::ROW_FIELD_W-1:0]    next_row,
	output logic [tccs_pkg::CELL_W-1:0]         read_cell
);
	import tccs_pkg::*;

	localparam int CELLS  = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int COL_W  = (SCREEN_COLUMNS > 1) ? $clog2(SCREEN_COLUMNS) : 1;
	localparam int ROW_W  = $clog2(SCREEN_ROWS);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CMP_W  = 9;   // wide enough for the column limit and the field

	logic [COL_W-1:0]  cur_col_q, col_n, col_clamp, ccol_q;
	logic [ROW_W-1:0]  cur_row_q, row_n, row_clamp, crow_q;
	logic [ADDR_W-1:0] ptr_q, ptr_n, ptr_up, cursor_addr, cell_addr, waddr, raddr;
	logic [BYTE_W-1:0] char_q, attr_q, clear_attr_q, scroll_attr_q;
	logic [CELL_W-1:0] wdata, rdata_q;
	logic [CELL_W-1:0] mem [CELLS];
	logic              col_end, row_end, mem_we, mem_re;
	logic [CMP_W-1:0]  col_wide, row_wide;

	// saturate requested position to the screen
	always_comb begin
		col_wide = CMP_W'(cell_column);
		row_wide = CMP_W'(cell_row);
		if (col_wide >= CMP_W'(SCREEN_COLUMNS)) col_clamp = COL_W'(SCREEN_COLUMNS - 1);
		else col_clamp = col_wide[COL_W-1:0];
		if (row_wide >= CMP_W'(SCREEN_ROWS)) row_clamp = ROW_W'(SCREEN_ROWS - 1);
		else row_clamp = row_wide[ROW_W-1:0];
	end

	assign col_end = (cur_col_q == COL_W'(SCREEN_COLUMNS - 1));
	assign row_end = (cur_row_q == ROW_W'(SCREEN_ROWS - 1));

	always_comb begin
		col_n = cur_col_q;
		row_n = cur_row_q;
		case (ctrl.uw.cur_op)
			CUR_ADVANCE: begin
				if (col_end) begin
					col_n = '0;
					// bottom row stays put: that is where a scroll leaves it
					if (!row_end) row_n = cur_row_q + 1'b1;
				end else begin
					col_n = cur_col_q + 1'b1;
				end
			end
			CUR_HOME: begin
				col_n = '0;
				row_n = '0;
			end
			CUR_LOAD: begin
				col_n = ccol_q;
				row_n = crow_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		case (ctrl.uw.ptr_op)
			PTR_ZERO:     ptr_n = '0;
			PTR_COLUMNS:  ptr_n = ADDR_W'(SCREEN_COLUMNS);
			PTR_LAST_ROW: ptr_n = ADDR_W'(CELLS - SCREEN_COLUMNS);
			PTR_INC:      ptr_n = ptr_q + 1'b1;
			default:      ptr_n = ptr_q;
		endcase
	end

	assign cursor_addr = ADDR_W'(32'(cur_row_q) * SCREEN_COLUMNS + 32'(cur_col_q));
	assign cell_addr   = ADDR_W'(32'(crow_q) * SCREEN_COLUMNS + 32'(ccol_q));
	assign ptr_up      = ptr_q - ADDR_W'(SCREEN_COLUMNS);

	always_comb begin
		case (ctrl.uw.waddr)
			WA_PTR:    waddr = ptr_q;
			WA_PTR_UP: waddr = ptr_up;
			default:   waddr = cursor_addr;
		endcase
		case (ctrl.uw.wsel)
			WD_COPY:         wdata = rdata_q;
			WD_SCROLL_BLANK: wdata = {scroll_attr_q, BLANK_CHAR};
			WD_CLEAR_BLANK:  wdata = {clear_attr_q, BLANK_CHAR};
			default:         wdata = {attr_q, char_q};
		endcase
		raddr = (ctrl.uw.raddr == RA_CELL) ? cell_addr : ptr_q;
	end

	assign mem_we = ctrl.go && ctrl.uw.mem_we;
	assign mem_re = ctrl.go && ctrl.uw.mem_re;

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		if (mem_re) rdata_q <= mem[raddr];
	end

	// transaction fields, captured on accept
	always_ff @(posedge clk) begin
		if (ctrl.go && ctrl.uw.latch_in) begin
			char_q <= character;
			attr_q <= attribute;
			ccol_q <= col_clamp;
			crow_q <= row_clamp;
		end
		if (ctrl.go) ptr_q <= ptr_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q     <= '0;
			cur_row_q     <= '0;
			clear_attr_q  <= ATTR_RESET;
			scroll_attr_q <= ATTR_RESET;
		end else begin
			if (ctrl.go) begin
				cur_col_q <= col_n;
				cur_row_q <= row_n;
			end
			if (cfg_write) begin
				case (reg_idx_e'(cfg_index))
					REG_CLEAR_ATTR:  clear_attr_q  <= cfg_data;
					REG_SCROLL_ATTR: scroll_attr_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	assign stat.ptr_last   = (ptr_q == ADDR_W'(CELLS - 1));
	assign stat.screen_end = col_end && row_end;
	assign next_column     = COL_FIELD_W'(col_n);
	assign next_row        = ROW_FIELD_W'(row_n);
	assign read_cell       = rdata_q;

	`ASSERT_ALWAYS(a_cursor_range,
		(32'(cur_col_q) < SCREEN_COLUMNS) && (32'(cur_row_q) < SCREEN_ROWS),
		"cursor outside the screen")
	`ASSERT_IMPL(a_waddr_range, mem_we, 32'(waddr) < CELLS, "cell write outside the store")

endmodule
